/* hdl/nibcpu_pkg.sv */
// Shared types and constants for the nibble processor core.
// No dependencies; every other file in the project uses this package.
package nibcpu_pkg;

    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;
    localparam int NIB_W    = 4;
    localparam int PC_W     = 8;
    localparam int CELLS    = 16;
    localparam int CELL_AW  = 4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_RUN    = 2'd0,
        ACT_LOAD   = 2'd1,
        ACT_SET_IN = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [NIB_W-1:0] {
        OP_NOP = 4'd0,
        OP_STA = 4'd1,
        OP_LDA = 4'd2,
        OP_ADM = 4'd3,
        OP_SBM = 4'd4,
        OP_IMA = 4'd5,
        OP_ADI = 4'd6,
        OP_SBI = 4'd7,
        OP_JP  = 4'd8,
        OP_JPZ = 4'd9,
        OP_JPN = 4'd10,
        OP_IN  = 4'd11,
        OP_OUT = 4'd12
    } t_opcode;

    // Architectural state that every instruction may change.
    typedef struct packed {
        logic [NIB_W-1:0] acc;
        logic             zero;
        logic [PC_W-1:0]  pc;
        logic [NIB_W-1:0] out_port;
    } t_core_state;

    // Data cell write request from the execute logic.
    typedef struct packed {
        logic               we;
        logic [CELL_AW-1:0] idx;
    } t_cell_req;

endpackage

/* hdl/nibcpu_if.sv */
// Valid/ready channel interfaces for the nibble processor core.
// Depends on nibcpu_pkg for the field widths.
interface nibcpu_in_if;
    logic                              valid;
    logic                              ready;
    logic [nibcpu_pkg::ACTION_W-1:0]   action;
    logic [nibcpu_pkg::BYTE_W-1:0]     address;
    logic [nibcpu_pkg::BYTE_W-1:0]     value;

    modport source (output valid, output action, output address, output value,
                    input ready);
    modport sink   (input valid, input action, input address, input value,
                    output ready);
endinterface

interface nibcpu_out_if;
    logic                          valid;
    logic                          ready;
    logic [nibcpu_pkg::NIB_W-1:0]  accumulator;
    logic                          zero_flag;
    logic [nibcpu_pkg::PC_W-1:0]   program_counter;
    logic [nibcpu_pkg::NIB_W-1:0]  output_port;

    modport source (output valid, output accumulator, output zero_flag,
                    output program_counter, output output_port, input ready);
    modport sink   (input valid, input accumulator, input zero_flag,
                    input program_counter, input output_port, output ready);
endinterface

/* hdl/nibcpu_prog_mem.sv */
// Program store: one write port and two registered read ports, write-first.
// Per-entry valid bits make never-written entries read as zero after reset.
// Depends on nibcpu_pkg.
module nibcpu_prog_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [nibcpu_pkg::BYTE_W-1:0] i_wdata,
    input  logic [AW-1:0]                 i_raddr0,
    input  logic [AW-1:0]                 i_raddr1,
    output logic [nibcpu_pkg::BYTE_W-1:0] o_rdata0,
    output logic [nibcpu_pkg::BYTE_W-1:0] o_rdata1
);
    import nibcpu_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    logic [BYTE_W-1:0] r_rd0;
    logic [BYTE_W-1:0] r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    // The store reads as all zero after reset, so the read registers reset to zero too.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd0 <= '0;
            r_rd1 <= '0;
        end else begin
            if (i_we && (i_waddr == i_raddr0)) begin
                r_rd0 <= i_wdata;
            end else if (r_valid[i_raddr0]) begin
                r_rd0 <= r_mem[i_raddr0];
            end else begin
                r_rd0 <= '0;
            end
            if (i_we && (i_waddr == i_raddr1)) begin
                r_rd1 <= i_wdata;
            end else if (r_valid[i_raddr1]) begin
                r_rd1 <= r_mem[i_raddr1];
            end else begin
                r_rd1 <= '0;
            end
        end
    end

    assign o_rdata0 = r_rd0;
    assign o_rdata1 = r_rd1;

endmodule

/* hdl/nibcpu_exec.sv */
// Instruction decode and execute: next architectural state from the current
// state, the fetched instruction and operand bytes, and the data cell read.
// Depends on nibcpu_pkg.
module nibcpu_exec #(
    parameter int PROGRAM_BYTES = 64
) (
    input  logic                          i_run,
    input  nibcpu_pkg::t_core_state       i_state,
    input  logic [nibcpu_pkg::BYTE_W-1:0] i_instr,
    input  logic [nibcpu_pkg::BYTE_W-1:0] i_operand,
    input  logic [nibcpu_pkg::NIB_W-1:0]  i_cell_rdata,
    input  logic [nibcpu_pkg::NIB_W-1:0]  i_in_port,
    output nibcpu_pkg::t_cell_req         o_cell_req,
    output nibcpu_pkg::t_core_state       o_state
);
    import nibcpu_pkg::*;

    localparam logic [PC_W:0] PC_LIMIT = (PC_W+1)'(PROGRAM_BYTES);

    t_opcode          op;
    logic [NIB_W-1:0] nib;
    logic [PC_W-1:0]  pc_inc1;
    logic [PC_W-1:0]  pc_inc2;
    logic [PC_W-1:0]  pc_raw;
    logic [NIB_W-1:0] alu_res;
    logic             alu_flag;
    t_core_state      exec_state;

    assign op      = t_opcode'(i_instr[BYTE_W-1:NIB_W]);
    assign nib     = i_instr[NIB_W-1:0];
    assign pc_inc1 = i_state.pc + PC_W'(1);
    assign pc_inc2 = i_state.pc + PC_W'(2);

    always_comb begin
        exec_state = i_state;
        pc_raw     = pc_inc1;
        alu_res    = '0;
        alu_flag   = 1'b0;
        o_cell_req = '{we: 1'b0, idx: nib};
        unique case (op)
            OP_STA: o_cell_req.we = i_run;
            OP_LDA: exec_state.acc = i_cell_rdata;
            OP_ADM: begin
                alu_res  = i_state.acc + i_cell_rdata;
                alu_flag = 1'b1;
            end
            OP_SBM: begin
                alu_res  = i_state.acc - i_cell_rdata;
                alu_flag = 1'b1;
            end
            OP_IMA: exec_state.acc = nib;
            OP_ADI: begin
                alu_res  = i_state.acc + nib;
                alu_flag = 1'b1;
            end
            OP_SBI: begin
                alu_res  = i_state.acc - nib;
                alu_flag = 1'b1;
            end
            OP_JP:  pc_raw = i_operand;
            OP_JPZ: pc_raw = i_state.zero ? i_operand : pc_inc2;
            OP_JPN: pc_raw = i_state.zero ? pc_inc2 : i_operand;
            OP_IN:  exec_state.acc = i_in_port & nib;
            OP_OUT: exec_state.out_port = (i_state.acc & nib) | (i_state.out_port & ~nib);
            default: ;
        endcase
        if (alu_flag) begin
            exec_state.acc  = alu_res;
            exec_state.zero = (alu_res == '0);
        end
        // A program counter at or past the end of the store wraps to zero.
        exec_state.pc = ({1'b0, pc_raw} >= PC_LIMIT) ? '0 : pc_raw;
    end

    assign o_state = i_run ? exec_state : i_state;

endmodule

/* hdl/nibcpu_core.sv */
// Architectural registers, data cells and result register of the nibble
// processor; ties the program store and the execute logic together.
// Depends on nibcpu_pkg, nibcpu_if, nibcpu_prog_mem and nibcpu_exec.
module nibcpu_core #(
    parameter int PROGRAM_BYTES = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    nibcpu_in_if.sink      i_in,
    nibcpu_out_if.source   o_out
);
    import nibcpu_pkg::*;

    localparam int            AW       = $clog2(PROGRAM_BYTES);
    localparam logic [PC_W:0] PC_LIMIT = (PC_W+1)'(PROGRAM_BYTES);

    t_core_state       r_state;
    t_core_state       n_state;
    logic [NIB_W-1:0]  r_cells [CELLS];
    logic [NIB_W-1:0]  r_in_port;
    logic              r_out_valid;
    t_core_state       r_result;

    logic              accept;
    logic              run;
    logic              load_we;
    t_cell_req         cell_req;
    logic [BYTE_W-1:0] instr;
    logic [BYTE_W-1:0] operand;
    logic [PC_W:0]     next_op_addr;
    logic [AW-1:0]     raddr0;
    logic [AW-1:0]     raddr1;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign run        = accept && (t_action'(i_in.action) == ACT_RUN);
    assign load_we    = accept && (t_action'(i_in.action) == ACT_LOAD)
                        && ({1'b0, i_in.address} < PC_LIMIT);

    // The store is read at the program counter that the next item will see,
    // so the instruction and its operand byte are waiting when it arrives.
    assign next_op_addr = {1'b0, n_state.pc} + (PC_W+1)'(1);
    assign raddr0       = n_state.pc[AW-1:0];
    assign raddr1       = (next_op_addr >= PC_LIMIT) ? '0 : next_op_addr[AW-1:0];

    nibcpu_prog_mem #(
        .DEPTH (PROGRAM_BYTES),
        .AW    (AW)
    ) u_prog_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (load_we),
        .i_waddr  (i_in.address[AW-1:0]),
        .i_wdata  (i_in.value),
        .i_raddr0 (raddr0),
        .i_raddr1 (raddr1),
        .o_rdata0 (instr),
        .o_rdata1 (operand)
    );

    nibcpu_exec #(
        .PROGRAM_BYTES (PROGRAM_BYTES)
    ) u_exec (
        .i_run        (run),
        .i_state      (r_state),
        .i_instr      (instr),
        .i_operand    (operand),
        .i_cell_rdata (r_cells[instr[CELL_AW-1:0]]),
        .i_in_port    (r_in_port),
        .o_cell_req   (cell_req),
        .o_state      (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= '0;
            r_in_port <= '0;
            for (int i = 0; i < CELLS; i++) begin
                r_cells[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (cell_req.we) begin
                r_cells[cell_req.idx] <= r_state.acc;
            end
            if (accept && (t_action'(i_in.action) == ACT_SET_IN)) begin
                r_in_port <= i_in.value[NIB_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_state;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.accumulator     = r_result.acc;
    assign o_out.zero_flag       = r_result.zero;
    assign o_out.program_counter = r_result.pc;
    assign o_out.output_port     = r_result.out_port;

endmodule

/* hdl/nibble_cpu_core_top.sv */
// The nibble processor takes one item per clock cycle and delivers its result
// in the cycle after the transfer, from a result register; a new item is taken
// while that result still waits as long as the result is taken in the same
// cycle. An instruction finishes in the cycle it is accepted because the
// program store's two read ports, each with a registered output, already hold
// the instruction and operand bytes at the current program counter. The store
// needs no clearing pass: per-entry valid bits make it read as zero after reset.
// Depends on nibcpu_pkg, nibcpu_if and nibcpu_core.
module nibble_cpu_core_top #(
    parameter int PROGRAM_BYTES = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    nibcpu_in_if.sink      i_in,
    nibcpu_out_if.source   o_out
);
    import nibcpu_pkg::*;

    nibcpu_core #(
        .PROGRAM_BYTES (PROGRAM_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

/* bench/nibcpu_state_check.sv */
// Result checker for the nibble processor: keeps its own copy of the core state,
// predicts the state after every input transfer and compares each result transfer.
// Depends on nibcpu_pkg and the channel interfaces in nibcpu_if.
module nibcpu_state_check #(
    parameter int PROGRAM_BYTES = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    nibcpu_in_if  i_in_ch,
    nibcpu_out_if i_out_ch,
    output int    o_fail_count,
    output int    o_pending
);
    import nibcpu_pkg::*;

    logic [BYTE_W-1:0] prog_image [PROGRAM_BYTES];
    logic [NIB_W-1:0]  cell_image [CELLS];
    logic [NIB_W-1:0]  in_port;
    t_core_state       core;
    t_core_state       pending_states [$];
    int                fails;
    int                result_no;

    // Bytes past the end of the store read as zero.
    function automatic logic [BYTE_W-1:0] prog_byte(input int addr);
        return (addr < PROGRAM_BYTES) ? prog_image[addr] : '0;
    endfunction

    function automatic void exec_instruction();
        logic [BYTE_W-1:0] ibyte;
        logic [NIB_W-1:0]  op;
        logic [NIB_W-1:0]  n;
        int                opnd_addr;
        int                next_pc;
        ibyte     = prog_byte(int'(core.pc));
        op        = ibyte[7:4];
        n         = ibyte[3:0];
        opnd_addr = int'(core.pc) + 1;
        next_pc   = (int'(core.pc) + 1) % 256;
        // A jump at the last address takes its target from address 0.
        if (opnd_addr >= PROGRAM_BYTES) opnd_addr = 0;

        case (op)
            OP_STA: cell_image[n] = core.acc;
            OP_LDA: core.acc = cell_image[n];
            OP_ADM: begin
                core.acc  = core.acc + cell_image[n];
                core.zero = (core.acc == '0);
            end
            OP_SBM: begin
                core.acc  = core.acc - cell_image[n];
                core.zero = (core.acc == '0);
            end
            OP_IMA: core.acc = n;
            OP_ADI: begin
                core.acc  = core.acc + n;
                core.zero = (core.acc == '0);
            end
            OP_SBI: begin
                core.acc  = core.acc - n;
                core.zero = (core.acc == '0);
            end
            OP_JP:  next_pc = int'(prog_byte(opnd_addr));
            OP_JPZ: next_pc = core.zero ? int'(prog_byte(opnd_addr))
                                        : (int'(core.pc) + 2) % 256;
            OP_JPN: next_pc = !core.zero ? int'(prog_byte(opnd_addr))
                                         : (int'(core.pc) + 2) % 256;
            OP_IN:  core.acc = in_port & n;
            OP_OUT: core.out_port = (core.acc & n) | (core.out_port & ~n);
            default: ;
        endcase

        // Anything at or past the end of the store restarts at address 0.
        if (next_pc >= PROGRAM_BYTES) next_pc = 0;
        core.pc = next_pc[PC_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        t_core_state want;
        if (!i_rst_n) begin
            foreach (prog_image[i]) prog_image[i] = '0;
            foreach (cell_image[i]) cell_image[i] = '0;
            in_port = '0;
            core    = '0;
            fails   = 0;
            result_no = 0;
            pending_states.delete();
        end else begin
            // The result of a transfer leaves from a result register, never in the
            // transfer's own cycle, so results are retired before the new input is predicted.
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (pending_states.size() == 0) begin
                    if (fails < 10)
                        $display("checker: result %0d arrived with nothing outstanding",
                                 result_no);
                    fails++;
                end else begin
                    want = pending_states.pop_front();
                    if (i_out_ch.accumulator !== want.acc
                            || i_out_ch.zero_flag !== want.zero
                            || i_out_ch.program_counter !== want.pc
                            || i_out_ch.output_port !== want.out_port) begin
                        if (fails < 10)
                            $display({"checker: result %0d differs: acc %h/%h zero %b/%b ",
                                      "pc %h/%h out %h/%h (expected/actual)"},
                                     result_no, want.acc, i_out_ch.accumulator,
                                     want.zero, i_out_ch.zero_flag,
                                     want.pc, i_out_ch.program_counter,
                                     want.out_port, i_out_ch.output_port);
                        fails++;
                    end
                end
                result_no++;
            end

            if (i_in_ch.valid && i_in_ch.ready) begin
                case (t_action'(i_in_ch.action))
                    ACT_RUN:    exec_instruction();
                    ACT_LOAD:   if (int'(i_in_ch.address) < PROGRAM_BYTES)
                                    prog_image[int'(i_in_ch.address)] = i_in_ch.value;
                    ACT_SET_IN: in_port = i_in_ch.value[NIB_W-1:0];
                    default:    ;
                endcase
                pending_states.push_back(core);
            end
        end
        o_fail_count <= fails;
        o_pending    <= pending_states.size();
    end

endmodule

/* bench/nibble_cpu_core_top_tb.sv */
// Top of the nibble processor testbench: clock, reset, stimulus and verdict.
// Depends on nibcpu_pkg, nibcpu_if, nibble_cpu_core_top and nibcpu_state_check.
module nibble_cpu_core_top_tb;
    import nibcpu_pkg::*;

    localparam int STORE_BYTES  = 64;
    localparam int RANDOM_ITEMS = 600;
    localparam int CALM_ITEMS   = 60;
    localparam int STALL_LIMIT  = 1000;

    logic clk;
    logic rst_n;
    logic calm;
    int   fail_count;
    int   pending;
    int   dead_cycles = 0;

    nibcpu_in_if  in_ch ();
    nibcpu_out_if res_ch ();

    nibble_cpu_core_top #(
        .PROGRAM_BYTES(STORE_BYTES)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (res_ch)
    );

    nibcpu_state_check #(
        .PROGRAM_BYTES(STORE_BYTES)
    ) u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_ch     (in_ch),
        .i_out_ch    (res_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial begin
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Result side: ready drops in bursts of random length.
    initial begin
        int hold;
        hold = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold > 0) begin
                res_ch.ready <= 1'b0;
                hold--;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                hold = $urandom_range(0, 3);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Ends the run when no transfer happens on either channel for too long.
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            dead_cycles <= 0;
        end else if (dead_cycles == STALL_LIMIT) begin
            $display("nibble_cpu_core_top: mismatch");
            $finish;
        end else begin
            dead_cycles <= dead_cycles + 1;
        end
    end

    task automatic send_item(input t_action act, input logic [BYTE_W-1:0] addr,
                             input logic [BYTE_W-1:0] val);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.action  <= act;
        in_ch.address <= addr;
        in_ch.value   <= val;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    initial begin
        int r;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] val;
        calm          = 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.action  <= ACT_NONE;
        in_ch.address <= '0;
        in_ch.value   <= '0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);

        // Directed part. The unused action just reports the reset state, and
        // only the low nibble of the input port value is kept.
        send_item(ACT_NONE, 8'hFF, 8'hFF);
        send_item(ACT_SET_IN, 8'h00, 8'hFA);
        send_item(ACT_LOAD, 8'd0, {OP_IMA, 4'hF});
        send_item(ACT_LOAD, 8'd1, {OP_ADI, 4'h1});
        send_item(ACT_LOAD, 8'd2, {OP_JPZ, 4'h0});
        send_item(ACT_LOAD, 8'd3, BYTE_W'(STORE_BYTES - 1));
        send_item(ACT_LOAD, BYTE_W'(STORE_BYTES - 1), {OP_JP, 4'h0});
        // Loads past the end of the store are dropped.
        send_item(ACT_LOAD, 8'hFF, 8'h00);
        send_item(ACT_LOAD, BYTE_W'(STORE_BYTES), 8'h00);
        // Add wraps to zero and sets the flag, the taken jump lands on the last
        // address, and the jump there reads its target from address 0; that target
        // lies past the store and so restarts at 0.
        repeat (4) send_item(ACT_RUN, 8'h00, 8'h00);
        send_item(ACT_LOAD, 8'd1, {OP_SBI, 4'h1});
        send_item(ACT_LOAD, 8'd5, {OP_OUT, 4'hF});
        send_item(ACT_LOAD, 8'd6, {OP_IN, 4'hF});
        // Subtract clears the flag, the conditional jump falls through by two,
        // then a plain no-op, an output under a full mask and an input.
        repeat (6) send_item(ACT_RUN, 8'hFF, 8'hFF);

        // Random part: a store filled with random bytes runs every opcode and
        // random jump targets; half of the bytes stay below the store size so
        // that many jumps land inside the program.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            r    = $urandom_range(0, 99);
            addr = BYTE_W'($urandom);
            val  = BYTE_W'($urandom);
            if (r < 50) begin
                send_item(ACT_RUN, addr, val);
            end else if (r < 85) begin
                if ($urandom_range(0, 9) != 0)
                    addr = BYTE_W'($urandom_range(0, STORE_BYTES - 1));
                if ($urandom_range(0, 1) == 0)
                    val = BYTE_W'($urandom_range(0, STORE_BYTES - 1));
                send_item(ACT_LOAD, addr, val);
            end else if (r < 96) begin
                send_item(ACT_SET_IN, addr, val);
            end else begin
                send_item(ACT_NONE, addr, val);
            end
        end
        in_ch.valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
        if (fail_count == 0) begin
            $display("nibble_cpu_core_top: match");
        end else begin
            $display("nibble_cpu_core_top: mismatch");
        end
        $finish;
    end

endmodule
